// ===== sv/qsu_pkg.sv =====
package qsu_pkg;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_BODY = 2'd1;
  localparam logic [1:0] PH_ESC  = 2'd2;

  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_EOF     = 3'd1;
  localparam logic [2:0] ERR_NOQUOTE = 3'd2;
  localparam logic [2:0] ERR_EOL     = 3'd3;
  localparam logic [2:0] ERR_BADESC  = 3'd4;

  localparam logic [1:0] QUOTE_RUN_MAX = 2'd2;

  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LOW_R  = 8'h72;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;
  localparam logic [7:0] CH_LOW_T  = 8'h74;

  typedef struct packed {
    logic [1:0] phase;
    logic       single;
    logic [1:0] qcount;
    logic       multiline;
  } state_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic [2:0] fault_code;
    logic       input_taken;
    logic       string_ended;
  } res_t;

  typedef struct packed {
    logic [1:0] npre;
    logic [7:0] qbyte;
    logic       main_vld;
    res_t       main;
  } group_t;

endpackage

// ===== sv/qsu_decode.sv =====
module qsu_decode (
  input  qsu_pkg::state_t st_i,
  input  logic            allow_single_i,
  input  logic [7:0]      in_byte_i,
  input  logic            eoi_i,
  output qsu_pkg::group_t grp_o,
  output qsu_pkg::state_t nxt_o
);

  logic       closed;
  logic       is_q;
  logic       is_crlf;
  logic [7:0] qbyte;

  assign qbyte   = st_i.single ? qsu_pkg::CH_SQUOTE : qsu_pkg::CH_DQUOTE;
  assign is_q    = (in_byte_i == qbyte);
  assign is_crlf = (in_byte_i == qsu_pkg::CH_CR) || (in_byte_i == qsu_pkg::CH_LF);

  always_comb begin
    grp_o       = '0;
    grp_o.qbyte = qbyte;
    nxt_o       = st_i;
    closed      = 1'b0;
    unique case (st_i.phase)
      qsu_pkg::PH_IDLE: begin
        if (eoi_i) begin
          grp_o.main_vld        = 1'b1;
          grp_o.main.kind       = qsu_pkg::KIND_ERR;
          grp_o.main.fault_code = qsu_pkg::ERR_EOF;
        end else if (in_byte_i == qsu_pkg::CH_DQUOTE ||
                     (allow_single_i && in_byte_i == qsu_pkg::CH_SQUOTE)) begin
          nxt_o.phase     = qsu_pkg::PH_BODY;
          nxt_o.single    = (in_byte_i == qsu_pkg::CH_SQUOTE);
          nxt_o.qcount    = 2'd1;
          nxt_o.multiline = 1'b0;
        end else begin
          grp_o.main_vld        = 1'b1;
          grp_o.main.kind       = qsu_pkg::KIND_ERR;
          grp_o.main.fault_code = qsu_pkg::ERR_NOQUOTE;
        end
      end
      qsu_pkg::PH_ESC: begin
        grp_o.main_vld = 1'b1;
        if (eoi_i || is_crlf) begin
          grp_o.main.kind         = qsu_pkg::KIND_ERR;
          grp_o.main.fault_code   = eoi_i ? qsu_pkg::ERR_EOF : qsu_pkg::ERR_EOL;
          grp_o.main.string_ended = 1'b1;
          nxt_o.phase             = qsu_pkg::PH_IDLE;
          nxt_o.qcount            = 2'd0;
          nxt_o.multiline         = 1'b0;
        end else begin
          nxt_o.phase = qsu_pkg::PH_BODY;
          case (in_byte_i)
            qsu_pkg::CH_BSLASH, qsu_pkg::CH_SQUOTE, qsu_pkg::CH_DQUOTE: begin
              grp_o.main.out_byte = in_byte_i;
            end
            qsu_pkg::CH_LOW_R: grp_o.main.out_byte = qsu_pkg::CH_CR;
            qsu_pkg::CH_LOW_N: grp_o.main.out_byte = qsu_pkg::CH_LF;
            qsu_pkg::CH_LOW_T: grp_o.main.out_byte = qsu_pkg::CH_TAB;
            default: begin
              grp_o.main.kind        = qsu_pkg::KIND_ERR;
              grp_o.main.fault_code  = qsu_pkg::ERR_BADESC;
              grp_o.main.input_taken = 1'b1;
            end
          endcase
        end
      end
      default: begin
        if (eoi_i) begin
          grp_o.main_vld          = 1'b1;
          grp_o.main.string_ended = 1'b1;
          if (!st_i.multiline && st_i.qcount == qsu_pkg::QUOTE_RUN_MAX) begin
            grp_o.main.kind = qsu_pkg::KIND_DONE;
          end else begin
            grp_o.main.kind       = qsu_pkg::KIND_ERR;
            grp_o.main.fault_code = qsu_pkg::ERR_EOF;
          end
          nxt_o.phase     = qsu_pkg::PH_IDLE;
          nxt_o.qcount    = 2'd0;
          nxt_o.multiline = 1'b0;
        end else if (is_q) begin
          if (st_i.qcount == 2'd0) begin
            if (st_i.multiline) begin
              nxt_o.qcount = 2'd1;
            end else begin
              grp_o.main_vld          = 1'b1;
              grp_o.main.kind         = qsu_pkg::KIND_DONE;
              grp_o.main.input_taken  = 1'b1;
              grp_o.main.string_ended = 1'b1;
              nxt_o.phase             = qsu_pkg::PH_IDLE;
              nxt_o.qcount            = 2'd0;
              nxt_o.multiline         = 1'b0;
            end
          end else if (st_i.qcount >= qsu_pkg::QUOTE_RUN_MAX) begin
            if (st_i.multiline) begin
              grp_o.main_vld          = 1'b1;
              grp_o.main.kind         = qsu_pkg::KIND_DONE;
              grp_o.main.input_taken  = 1'b1;
              grp_o.main.string_ended = 1'b1;
              nxt_o.phase             = qsu_pkg::PH_IDLE;
              nxt_o.multiline         = 1'b0;
            end else begin
              nxt_o.multiline = 1'b1;
            end
            nxt_o.qcount = 2'd0;
          end else begin
            nxt_o.qcount = st_i.qcount + 2'd1;
          end
        end else begin
          if (st_i.qcount != 2'd0) begin
            if (st_i.multiline) begin
              grp_o.npre = st_i.qcount[1] ? qsu_pkg::QUOTE_RUN_MAX : st_i.qcount;
            end else if (st_i.qcount == qsu_pkg::QUOTE_RUN_MAX) begin
              grp_o.main_vld          = 1'b1;
              grp_o.main.kind         = qsu_pkg::KIND_DONE;
              grp_o.main.string_ended = 1'b1;
              nxt_o.phase             = qsu_pkg::PH_IDLE;
              nxt_o.multiline         = 1'b0;
              closed                  = 1'b1;
            end
            nxt_o.qcount = 2'd0;
          end
          if (!closed) begin
            if (is_crlf) begin
              if (st_i.multiline) begin
                if (in_byte_i == qsu_pkg::CH_LF) begin
                  grp_o.main_vld      = 1'b1;
                  grp_o.main.out_byte = in_byte_i;
                end
              end else begin
                grp_o.main_vld          = 1'b1;
                grp_o.main.kind         = qsu_pkg::KIND_ERR;
                grp_o.main.fault_code   = qsu_pkg::ERR_EOL;
                grp_o.main.string_ended = 1'b1;
                nxt_o.phase             = qsu_pkg::PH_IDLE;
                nxt_o.qcount            = 2'd0;
                nxt_o.multiline         = 1'b0;
              end
            end else if (in_byte_i == qsu_pkg::CH_BSLASH) begin
              nxt_o.phase = qsu_pkg::PH_ESC;
            end else begin
              grp_o.main_vld      = 1'b1;
              grp_o.main.out_byte = in_byte_i;
            end
          end
        end
      end
    endcase
  end

endmodule

// ===== sv/qsu_result_buf.sv =====
module qsu_result_buf (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  qsu_pkg::group_t grp_i,
  input  logic            pop_i,
  output logic            valid_o,
  output logic            last_o,
  output qsu_pkg::res_t   res_o
);

  logic [1:0]    npre_q, npre_d;
  logic          main_vld_q, main_vld_d;
  logic [7:0]    qbyte_q;
  qsu_pkg::res_t main_q;
  qsu_pkg::res_t quote_res;

  always_comb begin
    quote_res          = '0;
    quote_res.out_byte = qbyte_q;
    quote_res.kind     = qsu_pkg::KIND_BYTE;
  end

  assign valid_o = (npre_q != 2'd0) || main_vld_q;
  assign last_o  = (npre_q != 2'd0) ? (npre_q == 2'd1 && !main_vld_q) : 1'b1;
  assign res_o   = (npre_q != 2'd0) ? quote_res : main_q;

  always_comb begin
    npre_d     = npre_q;
    main_vld_d = main_vld_q;
    if (load_i) begin
      npre_d     = grp_i.npre;
      main_vld_d = grp_i.main_vld;
    end else if (pop_i) begin
      if (npre_q != 2'd0) begin
        npre_d = npre_q - 2'd1;
      end else begin
        main_vld_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      npre_q     <= 2'd0;
      main_vld_q <= 1'b0;
    end else begin
      npre_q     <= npre_d;
      main_vld_q <= main_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      qbyte_q <= grp_i.qbyte;
      main_q  <= grp_i.main;
    end
  end

endmodule

// ===== sv/quoted_string_unescaper_unit.sv =====
// Channel   Direction  Handshake               Payload
// in        input      in_valid_i/in_ready_o   in_byte_i, end_of_input_i
// out       output     out_valid_o/out_ready_i out_byte_o, kind_o, fault_code_o,
//                                              input_taken_o, string_ended_o, last_o
// cfg       input      cfg_valid_i/cfg_ready_o allow_single_quote_i
//
// Each request is decoded in the cycle it is accepted and its results land in the
// output register, which presents them one per cycle while out_ready_i is high.
// The next request can be accepted in the same cycle as the last result of the one
// before it is taken, or straight away if that one gave no result.
// Reset returns the parser to idle and clears the single quote enable.
// A stalled output holds the input off until its last result is taken.
module quoted_string_unescaper_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_input_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic [1:0] kind_o,
  output logic [2:0] fault_code_o,
  output logic       input_taken_o,
  output logic       string_ended_o,
  output logic       last_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       allow_single_quote_i
);

  qsu_pkg::state_t st_q, st_d;
  qsu_pkg::group_t grp;
  qsu_pkg::res_t   res;
  logic            allow_single_q;
  logic            in_acc;
  logic            out_acc;

  assign cfg_ready_o = 1'b1;
  assign out_acc     = out_valid_o && out_ready_i;
  assign in_ready_o  = !out_valid_o || (out_ready_i && last_o);
  assign in_acc      = in_valid_i && in_ready_o;

  qsu_decode u_decode (
    .st_i          (st_q),
    .allow_single_i(allow_single_q),
    .in_byte_i     (in_byte_i),
    .eoi_i         (end_of_input_i),
    .grp_o         (grp),
    .nxt_o         (st_d)
  );

  qsu_result_buf u_result_buf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (in_acc),
    .grp_i  (grp),
    .pop_i  (out_acc),
    .valid_o(out_valid_o),
    .last_o (last_o),
    .res_o  (res)
  );

  assign out_byte_o     = res.out_byte;
  assign kind_o         = res.kind;
  assign fault_code_o   = res.fault_code;
  assign input_taken_o  = res.input_taken;
  assign string_ended_o = res.string_ended;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q           <= '0;
      allow_single_q <= 1'b0;
    end else begin
      if (in_acc) begin
        st_q <= st_d;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        allow_single_q <= allow_single_quote_i;
      end
    end
  end

  a_idle_eoi_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && st_q.phase == qsu_pkg::PH_IDLE && end_of_input_i |=>
      out_valid_o && kind_o == qsu_pkg::KIND_ERR && fault_code_o == qsu_pkg::ERR_EOF)
    else $error("end of input while idle did not report an error");

  a_ended_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && string_ended_o |-> st_q.phase == qsu_pkg::PH_IDLE)
    else $error("string end shown while parser is not idle");

  a_quote_run_ml: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> st_q.multiline && kind_o == qsu_pkg::KIND_BYTE)
    else $error("multiple results outside a multiline quote run");

  a_esc_no_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.phase == qsu_pkg::PH_ESC |-> st_q.qcount == 2'd0)
    else $error("pending quote run after a backslash");

endmodule

// ===== dv/tb_top.sv =====
module tb_top;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 200;

  typedef struct packed {
    qsu_pkg::res_t r;
    logic          last;
  } out_item_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid = 1'b0;
  logic [7:0] in_byte = 8'h00;
  logic       in_eoi = 1'b0;
  logic       out_ready = 1'b0;
  logic       cfg_valid = 1'b0;
  logic       cfg_allow = 1'b0;
  logic       hold_go = 1'b0;
  logic       out_hold = 1'b0;

  logic       in_ready_o;
  logic       out_valid_o;
  logic [7:0] out_byte_o;
  logic [1:0] kind_o;
  logic [2:0] fault_code_o;
  logic       input_taken_o;
  logic       string_ended_o;
  logic       last_o;
  logic       cfg_ready_o;

  int          idle_pct = 0;
  int          stall_pct = 0;
  int          items_sent = 0;
  int          fails = 0;
  int unsigned cycles = 0;

  logic [1:0] st_phase = qsu_pkg::PH_IDLE;
  logic       st_single = 1'b0;
  logic [1:0] st_qcount = 2'd0;
  logic       st_multi = 1'b0;
  logic       cfg_single = 1'b0;

  out_item_t pending_out[$];
  out_item_t head;

  quoted_string_unescaper_unit u_dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid),
    .in_ready_o           (in_ready_o),
    .in_byte_i            (in_byte),
    .end_of_input_i       (in_eoi),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready),
    .out_byte_o           (out_byte_o),
    .kind_o               (kind_o),
    .fault_code_o         (fault_code_o),
    .input_taken_o        (input_taken_o),
    .string_ended_o       (string_ended_o),
    .last_o               (last_o),
    .cfg_valid_i          (cfg_valid),
    .cfg_ready_o          (cfg_ready_o),
    .allow_single_quote_i (cfg_allow)
  );

  always #1 clk_i = ~clk_i;

  function automatic qsu_pkg::res_t mk(input logic [7:0] b, input logic [1:0] k,
                                       input logic [2:0] e, input logic taken,
                                       input logic ended);
    qsu_pkg::res_t r;
    r.out_byte = b;
    r.kind = k;
    r.fault_code = e;
    r.input_taken = taken;
    r.string_ended = ended;
    return r;
  endfunction

  function automatic void close_string();
    st_phase = qsu_pkg::PH_IDLE;
    st_qcount = 2'd0;
    st_multi = 1'b0;
  endfunction

  function automatic void unescape_step(input logic [7:0] b, input logic eoi);
    qsu_pkg::res_t outs[$];
    out_item_t     item;
    logic [7:0]    qc;
    logic          closed;
    int            i;
    qc = st_single ? qsu_pkg::CH_SQUOTE : qsu_pkg::CH_DQUOTE;
    closed = 1'b0;
    if (st_phase == qsu_pkg::PH_IDLE) begin
      if (eoi) begin
        outs.push_back(mk(8'h00, qsu_pkg::KIND_ERR, qsu_pkg::ERR_EOF, 1'b0, 1'b0));
      end else if (b == qsu_pkg::CH_DQUOTE || (cfg_single && b == qsu_pkg::CH_SQUOTE)) begin
        st_phase = qsu_pkg::PH_BODY;
        st_single = (b == qsu_pkg::CH_SQUOTE);
        st_qcount = 2'd1;
        st_multi = 1'b0;
      end else begin
        outs.push_back(mk(8'h00, qsu_pkg::KIND_ERR, qsu_pkg::ERR_NOQUOTE, 1'b0, 1'b0));
      end
    end else if (st_phase == qsu_pkg::PH_ESC) begin
      if (eoi) begin
        outs.push_back(mk(8'h00, qsu_pkg::KIND_ERR, qsu_pkg::ERR_EOF, 1'b0, 1'b1));
        close_string();
      end else if (b == qsu_pkg::CH_CR || b == qsu_pkg::CH_LF) begin
        outs.push_back(mk(8'h00, qsu_pkg::KIND_ERR, qsu_pkg::ERR_EOL, 1'b0, 1'b1));
        close_string();
      end else begin
        st_phase = qsu_pkg::PH_BODY;
        case (b)
          qsu_pkg::CH_BSLASH, qsu_pkg::CH_SQUOTE, qsu_pkg::CH_DQUOTE: begin
            outs.push_back(mk(b, qsu_pkg::KIND_BYTE, qsu_pkg::ERR_NONE, 1'b0, 1'b0));
          end
          qsu_pkg::CH_LOW_R: outs.push_back(mk(qsu_pkg::CH_CR, qsu_pkg::KIND_BYTE,
                                               qsu_pkg::ERR_NONE, 1'b0, 1'b0));
          qsu_pkg::CH_LOW_N: outs.push_back(mk(qsu_pkg::CH_LF, qsu_pkg::KIND_BYTE,
                                               qsu_pkg::ERR_NONE, 1'b0, 1'b0));
          qsu_pkg::CH_LOW_T: outs.push_back(mk(qsu_pkg::CH_TAB, qsu_pkg::KIND_BYTE,
                                               qsu_pkg::ERR_NONE, 1'b0, 1'b0));
          default: outs.push_back(mk(8'h00, qsu_pkg::KIND_ERR, qsu_pkg::ERR_BADESC,
                                     1'b1, 1'b0));
        endcase
      end
    end else if (eoi) begin
      if (!st_multi && st_qcount == qsu_pkg::QUOTE_RUN_MAX) begin
        outs.push_back(mk(8'h00, qsu_pkg::KIND_DONE, qsu_pkg::ERR_NONE, 1'b0, 1'b1));
      end else begin
        outs.push_back(mk(8'h00, qsu_pkg::KIND_ERR, qsu_pkg::ERR_EOF, 1'b0, 1'b1));
      end
      close_string();
    end else if (b == qc) begin
      if (st_qcount == 2'd0) begin
        if (st_multi) begin
          st_qcount = 2'd1;
        end else begin
          outs.push_back(mk(8'h00, qsu_pkg::KIND_DONE, qsu_pkg::ERR_NONE, 1'b1, 1'b1));
          close_string();
        end
      end else if (st_qcount == qsu_pkg::QUOTE_RUN_MAX) begin
        if (st_multi) begin
          outs.push_back(mk(8'h00, qsu_pkg::KIND_DONE, qsu_pkg::ERR_NONE, 1'b1, 1'b1));
          close_string();
        end else begin
          st_multi = 1'b1;
          st_qcount = 2'd0;
        end
      end else begin
        st_qcount = st_qcount + 2'd1;
      end
    end else begin
      if (st_qcount != 2'd0) begin
        if (st_multi) begin
          for (i = 0; i < st_qcount; i++) begin
            outs.push_back(mk(qc, qsu_pkg::KIND_BYTE, qsu_pkg::ERR_NONE, 1'b0, 1'b0));
          end
        end else if (st_qcount == qsu_pkg::QUOTE_RUN_MAX) begin
          outs.push_back(mk(8'h00, qsu_pkg::KIND_DONE, qsu_pkg::ERR_NONE, 1'b0, 1'b1));
          close_string();
          closed = 1'b1;
        end
        st_qcount = 2'd0;
      end
      if (!closed) begin
        if (b == qsu_pkg::CH_CR || b == qsu_pkg::CH_LF) begin
          if (st_multi) begin
            if (b == qsu_pkg::CH_LF) begin
              outs.push_back(mk(b, qsu_pkg::KIND_BYTE, qsu_pkg::ERR_NONE, 1'b0, 1'b0));
            end
          end else begin
            outs.push_back(mk(8'h00, qsu_pkg::KIND_ERR, qsu_pkg::ERR_EOL, 1'b0, 1'b1));
            close_string();
          end
        end else if (b == qsu_pkg::CH_BSLASH) begin
          st_phase = qsu_pkg::PH_ESC;
        end else begin
          outs.push_back(mk(b, qsu_pkg::KIND_BYTE, qsu_pkg::ERR_NONE, 1'b0, 1'b0));
        end
      end
    end
    foreach (outs[j]) begin
      item.r = outs[j];
      item.last = (j == outs.size() - 1);
      pending_out.push_back(item);
    end
  endfunction

  function automatic void field_mismatch(input string name, input logic [7:0] want,
                                         input logic [7:0] got);
    fails++;
    $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready) begin
      if (pending_out.size() == 0) begin
        fails++;
        $display("%0t: unexpected result: expected none, actual kind %0h byte %0h",
                 $time, kind_o, out_byte_o);
      end else begin
        head = pending_out.pop_front();
        if (out_byte_o !== head.r.out_byte)
          field_mismatch("out_byte", head.r.out_byte, out_byte_o);
        if (kind_o !== head.r.kind)
          field_mismatch("kind", 8'(head.r.kind), 8'(kind_o));
        if (fault_code_o !== head.r.fault_code)
          field_mismatch("fault_code", 8'(head.r.fault_code), 8'(fault_code_o));
        if (input_taken_o !== head.r.input_taken)
          field_mismatch("input_taken", 8'(head.r.input_taken), 8'(input_taken_o));
        if (string_ended_o !== head.r.string_ended)
          field_mismatch("string_ended", 8'(head.r.string_ended), 8'(string_ended_o));
        if (last_o !== head.last)
          field_mismatch("last", 8'(head.last), 8'(last_o));
      end
    end
  end

  always @(posedge clk_i) begin
    out_ready <= !out_hold && ($urandom_range(99) >= stall_pct);
  end

  // The output is held off for a long stretch once, so the block fills up.
  initial begin
    wait (hold_go);
    @(posedge clk_i);
    out_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    out_hold <= 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // The ready output only changes at a rising edge, so its value between edges
  // tells whether the coming edge accepts the request.
  task automatic send_item(input logic [7:0] b, input logic eoi);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    in_eoi <= eoi;
    @(negedge clk_i);
    while (!in_ready_o) @(negedge clk_i);
    @(posedge clk_i);
    unescape_step(b, eoi);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_allow(input logic v);
    cfg_valid <= 1'b1;
    cfg_allow <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid <= 1'b0;
    cfg_single = v;
  endtask

  task automatic send_random_string();
    logic [7:0] qc;
    logic [7:0] c;
    logic       triple;
    int         n;
    int         k;
    int         r;
    qc = (cfg_single && $urandom_range(1)) ? qsu_pkg::CH_SQUOTE : qsu_pkg::CH_DQUOTE;
    triple = ($urandom_range(3) == 0);
    n = $urandom_range(8);
    repeat (triple ? 3 : 1) send_item(qc, 1'b0);
    for (k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 50) begin
        c = 8'($urandom_range(255));
        if (c == qc || c == qsu_pkg::CH_BSLASH || c == qsu_pkg::CH_CR ||
            c == qsu_pkg::CH_LF)
          c = 8'h61 + 8'($urandom_range(25));
        send_item(c, 1'b0);
      end else if (r < 70) begin
        send_item(qsu_pkg::CH_BSLASH, 1'b0);
        case ($urandom_range(5))
          0: c = qsu_pkg::CH_BSLASH;
          1: c = qsu_pkg::CH_SQUOTE;
          2: c = qsu_pkg::CH_DQUOTE;
          3: c = qsu_pkg::CH_LOW_R;
          4: c = qsu_pkg::CH_LOW_N;
          default: c = qsu_pkg::CH_LOW_T;
        endcase
        send_item(c, 1'b0);
      end else if (r < 76) begin
        send_item(qsu_pkg::CH_BSLASH, 1'b0);
        send_item(8'($urandom_range(255)), 1'b0);
      end else if (r < 88) begin
        if (triple) begin
          repeat ($urandom_range(1, 2)) send_item(qc, 1'b0);
          send_item(8'h61 + 8'($urandom_range(25)), 1'b0);
        end else begin
          send_item((qc == qsu_pkg::CH_DQUOTE) ? qsu_pkg::CH_SQUOTE : qsu_pkg::CH_DQUOTE,
                    1'b0);
        end
      end else if (r < 96) begin
        if (triple) send_item($urandom_range(1) ? qsu_pkg::CH_CR : qsu_pkg::CH_LF, 1'b0);
        else send_item(qsu_pkg::CH_TAB, 1'b0);
      end else begin
        send_item(8'($urandom_range(255)), $urandom_range(9) == 0);
      end
    end
    r = $urandom_range(99);
    if (r < 88) begin
      repeat (triple ? 3 : 1) send_item(qc, 1'b0);
      if (!triple && n == 0) send_item(8'h20, $urandom_range(1));
    end else if (r < 94) begin
      send_item(8'($urandom_range(255)), 1'b1);
    end else begin
      send_item(qsu_pkg::CH_LF, 1'b0);
    end
  endtask

  task automatic test_directed();
    idle_pct = 0;
    stall_pct = 0;
    send_item(8'h00, 1'b1);
    send_item(8'h61, 1'b0);
    send_item(qsu_pkg::CH_SQUOTE, 1'b0);
    send_item(qsu_pkg::CH_DQUOTE, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(qsu_pkg::CH_BSLASH, 1'b0);
    send_item(8'h78, 1'b0);
    send_item(qsu_pkg::CH_BSLASH, 1'b0);
    send_item(qsu_pkg::CH_LOW_N, 1'b0);
    send_item(qsu_pkg::CH_LF, 1'b0);
    repeat (4) send_item(qsu_pkg::CH_DQUOTE, 1'b0);
    send_item(8'h61, 1'b0);
    send_item(qsu_pkg::CH_CR, 1'b0);
    send_item(qsu_pkg::CH_LF, 1'b0);
    repeat (3) send_item(qsu_pkg::CH_DQUOTE, 1'b0);
    repeat (2) send_item(qsu_pkg::CH_DQUOTE, 1'b0);
    send_item(8'h62, 1'b0);
    send_item(qsu_pkg::CH_DQUOTE, 1'b0);
    send_item(qsu_pkg::CH_BSLASH, 1'b0);
    send_item(qsu_pkg::CH_CR, 1'b0);
  endtask

  task automatic test_single_quote();
    wait_drained();
    write_allow(1'b1);
    send_item(qsu_pkg::CH_SQUOTE, 1'b0);
    send_item(qsu_pkg::CH_DQUOTE, 1'b0);
    send_item(qsu_pkg::CH_BSLASH, 1'b0);
    send_item(qsu_pkg::CH_SQUOTE, 1'b0);
    send_item(qsu_pkg::CH_BSLASH, 1'b0);
    send_item(qsu_pkg::CH_DQUOTE, 1'b0);
    send_item(qsu_pkg::CH_BSLASH, 1'b0);
    send_item(qsu_pkg::CH_BSLASH, 1'b0);
    send_item(qsu_pkg::CH_BSLASH, 1'b0);
    send_item(qsu_pkg::CH_LOW_R, 1'b0);
    send_item(qsu_pkg::CH_BSLASH, 1'b0);
    send_item(qsu_pkg::CH_LOW_T, 1'b0);
    send_item(qsu_pkg::CH_SQUOTE, 1'b0);
    repeat (2) send_item(qsu_pkg::CH_DQUOTE, 1'b0);
    send_item(8'h00, 1'b1);
    send_item(qsu_pkg::CH_DQUOTE, 1'b0);
    send_item(8'h61, 1'b0);
    send_item(8'hFF, 1'b1);
    send_item(qsu_pkg::CH_SQUOTE, 1'b0);
    send_item(qsu_pkg::CH_BSLASH, 1'b0);
    send_item(8'h00, 1'b1);
  endtask

  task automatic test_random_phase(input logic allow, input int sidle, input int rstall,
                                   input int n);
    int start;
    wait_drained();
    write_allow(allow);
    idle_pct = sidle;
    stall_pct = rstall;
    start = items_sent;
    while (items_sent - start < n) begin
      if ($urandom_range(19) == 0) send_item(8'($urandom_range(255)), $urandom_range(3) == 0);
      else send_random_string();
    end
  endtask

  task automatic test_backpressure();
    wait_drained();
    idle_pct = 0;
    stall_pct = 0;
    hold_go <= 1'b1;
    repeat (6) send_random_string();
    wait_drained();
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_single_quote();
    test_random_phase(1'b1, 0, 0, 95);
    test_random_phase(1'b0, 87, 0, 95);
    test_random_phase(1'b1, 0, 87, 95);
    test_random_phase(1'b0, 23, 23, 95);
    test_backpressure();
    wait_drained();
    if (fails == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
